>>> rtl/core/fbfgs_pkg.sv
package fbfgs_pkg;

	// frame store geometry
	localparam int MAX_FRAME_BYTES = 64;
	localparam int ADDR_W = $clog2(MAX_FRAME_BYTES);

	// field widths
	localparam int LEN_W = 7;
	localparam int OFS_W = 9;
	localparam int BLEN_W = 6;
	localparam int FIELD_W = 32;
	localparam int FIRST_W = OFS_W - 3;

	// byte window: up to five consecutive frame bytes
	localparam int LANES = 5;
	localparam int LANE_W = 3;
	localparam int WIN_W = 8 * LANES;

	// wide enough for frame positions and the effective length
	localparam int POS_W = ((LEN_W > ADDR_W) ? LEN_W : ADDR_W) + 2;

	localparam logic [LEN_W-1:0] FRAME_LEN_RESET = 7'd8;

	// access kinds
	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	// field mask: empty for zero length, full for 32 and above
	function automatic logic [FIELD_W-1:0] field_mask(input logic [BLEN_W-1:0] len);
		if (len == '0) begin
			return '0;
		end
		if (len >= BLEN_W'(FIELD_W)) begin
			return '1;
		end
		return (FIELD_W'(1) << len[4:0]) - FIELD_W'(1);
	endfunction

endpackage

>>> rtl/core/fbfgs_ram.sv
module fbfgs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/frame_bit_field_get_set.sv
// Items are taken one at a time: a new item is accepted only in the idle state. The
// single read port of the frame store walks the five window bytes one per cycle,
// with the write-back of each byte trailing in the cycle after its read.
// A finished result waits in an output register while a new item starts.
// Reset: frame_len returns to 8 and every store byte reads as zero through
// per-byte valid flags; there is no clearing pass.
module frame_bit_field_get_set (
	input logic clk,
	input logic arst_n,
	// frame_len register write
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [fbfgs_pkg::LEN_W-1:0] cfg_data,
	// input items
	input logic s_tvalid,
	output logic s_tready,
	input logic [47:0] s_tdata, // bit_offset[8:0], bit_length[14:9], write_value[46:15], zero
	input logic [1:0] s_tuser, // kind[0], byte_order[1]
	// result items
	output logic m_tvalid,
	input logic m_tready,
	output logic [31:0] m_tdata // read_value[31:0]
);

	localparam int AW = fbfgs_pkg::ADDR_W;
	localparam int PW = fbfgs_pkg::POS_W;
	localparam int WW = fbfgs_pkg::WIN_W;
	localparam int FW = fbfgs_pkg::FIELD_W;

	fbfgs_pkg::state_t state_q;
	logic [fbfgs_pkg::LANE_W-1:0] step_q;
	logic kind_q;
	logic rev_q;
	logic [fbfgs_pkg::FIRST_W-1:0] first_q;
	logic [2:0] rem_q;
	logic [FW-1:0] mask_q;
	logic [WW-1:0] m40_q;
	logic [WW-1:0] v40_q;
	logic [WW-1:0] window_q;
	logic [fbfgs_pkg::LEN_W-1:0] frame_len_q;
	logic [fbfgs_pkg::MAX_FRAME_BYTES-1:0] vld_q;
	logic out_vld_q;
	logic [FW-1:0] out_data_q;

	logic p_s1;
	logic [fbfgs_pkg::LANE_W-1:0] lane_s1;
	logic [AW-1:0] addr_s1;
	logic vld_s1;
	logic [7:0] bm_s1;
	logic [7:0] bv_s1;

	logic accept;
	logic [8:0] in_offset;
	logic [5:0] in_blen;
	logic [FW-1:0] in_wval;
	logic [FW-1:0] in_mask;
	logic [PW-1:0] eff_len;
	logic [PW-1:0] pos;
	logic [PW-1:0] rev_idx;
	logic [5:0] lane_bit;
	logic [5:0] lane_bit_s1;
	logic [7:0] lane_bm;
	logic [7:0] lane_bv;
	logic issue;
	logic lane_act;
	logic [AW-1:0] rd_addr;
	logic [7:0] ram_rdata;
	logic [7:0] rd_byte;
	logic wr_en;
	logic [7:0] wr_byte;
	logic [WW-1:0] win_sh;
	logic [FW-1:0] result;
	logic out_free;

	// input unpacking
	assign in_offset = s_tdata[8:0];
	assign in_blen = s_tdata[14:9];
	assign in_wval = s_tdata[46:15];
	assign in_mask = fbfgs_pkg::field_mask(in_blen);

	assign s_tready = (state_q == fbfgs_pkg::ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// effective frame length, saturated to the store size
	assign eff_len = (PW'(frame_len_q) > PW'(fbfgs_pkg::MAX_FRAME_BYTES)) ?
		PW'(fbfgs_pkg::MAX_FRAME_BYTES) : PW'(frame_len_q);

	// address of the current window byte
	assign pos = PW'(first_q) + PW'(step_q);
	assign rev_idx = eff_len - PW'(1) - pos;
	assign rd_addr = rev_q ? rev_idx[AW-1:0] : pos[AW-1:0];
	assign lane_bit = {step_q, 3'b000};
	assign lane_bm = m40_q[lane_bit +: 8];
	assign lane_bv = v40_q[lane_bit +: 8];

	// byte takes part if inside the frame, and on a write only if touched
	assign issue = (state_q == fbfgs_pkg::ST_RUN) &&
		(step_q < fbfgs_pkg::LANE_W'(fbfgs_pkg::LANES));
	assign lane_act = issue && (pos < eff_len) &&
		((kind_q == fbfgs_pkg::KIND_READ) || (lane_bm != 8'h00));

	// read data returns in the next cycle; modify and write back
	assign rd_byte = vld_s1 ? ram_rdata : 8'h00;
	assign wr_en = p_s1 && (kind_q == fbfgs_pkg::KIND_WRITE);
	assign wr_byte = (rd_byte & ~bm_s1) | bv_s1;
	assign lane_bit_s1 = {lane_s1, 3'b000};

	fbfgs_ram #(
		.WIDTH(8),
		.DEPTH(fbfgs_pkg::MAX_FRAME_BYTES)
	) u_store (
		.clk(clk),
		.we(wr_en),
		.waddr(addr_s1),
		.wdata(wr_byte),
		.re(lane_act),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	// result formation
	assign win_sh = window_q >> rem_q;
	assign result = (kind_q == fbfgs_pkg::KIND_WRITE) ? '0 : (win_sh[FW-1:0] & mask_q);
	assign out_free = !out_vld_q || m_tready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbfgs_pkg::ST_IDLE;
			step_q <= '0;
			p_s1 <= 1'b0;
		end else begin
			p_s1 <= lane_act;
			case (state_q)
				fbfgs_pkg::ST_IDLE: begin
					if (accept) begin
						state_q <= fbfgs_pkg::ST_RUN;
						step_q <= '0;
					end
				end
				fbfgs_pkg::ST_RUN: begin
					step_q <= step_q + fbfgs_pkg::LANE_W'(1);
					if (step_q == fbfgs_pkg::LANE_W'(fbfgs_pkg::LANES)) begin
						state_q <= fbfgs_pkg::ST_DONE;
					end
				end
				fbfgs_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= fbfgs_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= fbfgs_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// item payload captured at accept
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= s_tuser[0];
			rev_q <= s_tuser[1];
			first_q <= in_offset[8:3];
			rem_q <= in_offset[2:0];
			mask_q <= in_mask;
			m40_q <= WW'(in_mask) << in_offset[2:0];
			v40_q <= WW'(in_wval & in_mask) << in_offset[2:0];
		end
	end

	// read pipeline stage
	always_ff @(posedge clk) begin
		lane_s1 <= step_q;
		addr_s1 <= rd_addr;
		vld_s1 <= vld_q[rd_addr];
		bm_s1 <= lane_bm;
		bv_s1 <= lane_bv;
	end

	// gathered window
	always_ff @(posedge clk) begin
		if (accept) begin
			window_q <= '0;
		end else if (p_s1 && (kind_q == fbfgs_pkg::KIND_READ)) begin
			window_q[lane_bit_s1 +: 8] <= rd_byte;
		end
	end

	// per-byte written flags, unwritten bytes read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[addr_s1] <= 1'b1;
		end
	end

	// frame length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len_q <= fbfgs_pkg::FRAME_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			frame_len_q <= cfg_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if ((state_q == fbfgs_pkg::ST_DONE) && out_free) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == fbfgs_pkg::ST_DONE) && out_free) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = out_data_q;

endmodule
